@@ rtl/ssrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ssrt_pkg
// Shared definitions for the shared segment reference-count table: field
// widths, the table entry layout and the result status codes.
// ----------------------------------------------------------------------------
package ssrt_pkg;

  // default number of table entries
  localparam int TableEntries = 64;

  // payload field widths
  localparam int KeyW    = 32;
  localparam int FrameW  = 20;
  localparam int RefsW   = 8;
  localparam int SlotW   = 6;
  localparam int StatusW = 3;

  // count saturation value
  localparam logic [RefsW-1:0] RefsMax = {RefsW{1'b1}};

  // one table entry as stored in the RAM; a key of zero marks a free entry
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [FrameW-1:0] frame;
    logic [RefsW-1:0]  refs;
  } ssrt_entry_t;

  localparam int EntryW = $bits(ssrt_entry_t);

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StOpened    = 3'd0,
    StCreated   = 3'd1,
    StFull      = 3'd2,
    StShared    = 3'd3,
    StReleased  = 3'd4,
    StNotFound  = 3'd5,
    StInvalid   = 3'd6,
    StSaturated = 3'd7
  } ssrt_status_e;

endpackage

@@ rtl/shared_segment_refcount_table_top.sv @@
// ----------------------------------------------------------------------------
// shared_segment_refcount_table_top
// Table of shared segments (key, frame, reference count) held in one RAM.
// Open finds or creates an entry, close decrements every matching entry.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------------
//  command   in         start & !busy             opcode_i, segment_id_i, new_frame_i
//  result    out        done_o, one-cycle strobe  status_o, slot_o, frame_o,
//                                                 ref_count_o
//
//  A nonzero key runs a pass over the table: TableEntries reads at one a cycle, set
//  by the single read port, then the last read data is consumed and, for an open,
//  the entry is written back.
//  An item with a zero key is answered in the next cycle.
//  After reset a clearing pass writes zero to every RAM entry; busy is
//  high meanwhile. The receiver cannot stall; each result shows for one cycle.
//
module shared_segment_refcount_table_top #(
  parameter int TableEntries = ssrt_pkg::TableEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [ssrt_pkg::KeyW-1:0]     segment_id_i,
  input  logic [ssrt_pkg::FrameW-1:0]   new_frame_i,
  output logic                          done_o,
  output logic [ssrt_pkg::StatusW-1:0]  status_o,
  output logic [ssrt_pkg::SlotW-1:0]    slot_o,
  output logic [ssrt_pkg::FrameW-1:0]   frame_o,
  output logic [ssrt_pkg::RefsW-1:0]    ref_count_o
);

  localparam int AddrW = $clog2(TableEntries);
  localparam int CntW  = AddrW + 1;
  localparam logic [CntW-1:0] CntLast = CntW'(TableEntries - 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(TableEntries);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               cnt_q;
  logic                          rvalid_q;
  logic [AddrW-1:0]              ridx_q;
  logic                          op_q;
  logic [ssrt_pkg::KeyW-1:0]     key_q;
  logic [ssrt_pkg::FrameW-1:0]   nframe_q;
  logic                          hit_found_q;
  logic [AddrW-1:0]              hit_idx_q;
  logic [ssrt_pkg::FrameW-1:0]   hit_frame_q;
  logic [ssrt_pkg::RefsW-1:0]    hit_refs_q;
  logic                          free_found_q;
  logic [AddrW-1:0]              free_idx_q;
  logic                          done_q;
  ssrt_pkg::ssrt_status_e        status_q;
  logic [ssrt_pkg::SlotW-1:0]    slot_q;
  logic [ssrt_pkg::FrameW-1:0]   frame_q;
  logic [ssrt_pkg::RefsW-1:0]    refs_q;

  logic                          rd_en;
  logic [AddrW-1:0]              raddr;
  logic [ssrt_pkg::EntryW-1:0]   rdata;
  ssrt_pkg::ssrt_entry_t         rd_entry;
  logic                          we;
  logic [AddrW-1:0]              waddr;
  ssrt_pkg::ssrt_entry_t         wr_entry;
  logic                          match;
  logic                          is_free;
  logic [ssrt_pkg::RefsW-1:0]    dec_refs;
  logic                          scan_end;
  logic                          open_inc;

  // entry storage
  ssrt_ram #(
    .Width (ssrt_pkg::EntryW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // scan read side
  assign rd_en    = (state_q == S_SCAN) && (cnt_q != CntEnd);
  assign raddr    = cnt_q[AddrW-1:0];
  assign rd_entry = ssrt_pkg::ssrt_entry_t'(rdata);

  // per-entry compare on returned data
  assign match    = rvalid_q && (rd_entry.key == key_q);
  assign is_free  = rvalid_q && (rd_entry.key == '0);
  assign dec_refs = (rd_entry.refs != '0) ? rd_entry.refs - 1'b1 : '0;

  // pass complete: all reads issued and the last one consumed
  assign scan_end = (state_q == S_SCAN) && (cnt_q == CntEnd) && !rvalid_q;
  assign open_inc = hit_found_q && (hit_refs_q != ssrt_pkg::RefsMax);

  // write port: clearing pass, in-pass close updates, open write-back
  always_comb begin
    we       = 1'b0;
    waddr    = cnt_q[AddrW-1:0];
    wr_entry = '0;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end else if (match && op_q) begin
      // close: decrement, free the entry at zero
      we    = 1'b1;
      waddr = ridx_q;
      if (dec_refs != '0) begin
        wr_entry.key   = rd_entry.key;
        wr_entry.frame = rd_entry.frame;
        wr_entry.refs  = dec_refs;
      end
    end else if (scan_end && !op_q) begin
      if (open_inc) begin
        we             = 1'b1;
        waddr          = hit_idx_q;
        wr_entry.key   = key_q;
        wr_entry.frame = hit_frame_q;
        wr_entry.refs  = hit_refs_q + 1'b1;
      end else if (!hit_found_q && free_found_q) begin
        we             = 1'b1;
        waddr          = free_idx_q;
        wr_entry.key   = key_q;
        wr_entry.frame = nframe_q;
        wr_entry.refs  = ssrt_pkg::RefsW'(1);
      end
    end
  end

  // control state, scan tracking and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      rvalid_q     <= 1'b0;
      ridx_q       <= '0;
      op_q         <= 1'b0;
      key_q        <= '0;
      nframe_q     <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      hit_frame_q  <= '0;
      hit_refs_q   <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      done_q       <= 1'b0;
      status_q     <= ssrt_pkg::StOpened;
      slot_q       <= '0;
      frame_q      <= '0;
      refs_q       <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (segment_id_i == '0) begin
              // invalid key: answer at once, table untouched
              done_q   <= 1'b1;
              status_q <= ssrt_pkg::StInvalid;
              slot_q   <= '0;
              frame_q  <= '0;
              refs_q   <= '0;
            end else begin
              state_q      <= S_SCAN;
              cnt_q        <= '0;
              rvalid_q     <= 1'b0;
              op_q         <= opcode_i;
              key_q        <= segment_id_i;
              nframe_q     <= new_frame_i;
              hit_found_q  <= 1'b0;
              free_found_q <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          rvalid_q <= rd_en;
          ridx_q   <= raddr;
          if (rd_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
          // lowest match; close keeps the count after decrement
          if (match && !hit_found_q) begin
            hit_found_q <= 1'b1;
            hit_idx_q   <= ridx_q;
            hit_frame_q <= rd_entry.frame;
            hit_refs_q  <= op_q ? dec_refs : rd_entry.refs;
          end
          // lowest free entry
          if (is_free && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= ridx_q;
          end
          if (scan_end) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            if (!op_q) begin
              if (hit_found_q) begin
                status_q <= open_inc ? ssrt_pkg::StOpened : ssrt_pkg::StSaturated;
                slot_q   <= ssrt_pkg::SlotW'(hit_idx_q);
                frame_q  <= hit_frame_q;
                refs_q   <= open_inc ? hit_refs_q + 1'b1 : ssrt_pkg::RefsMax;
              end else if (free_found_q) begin
                status_q <= ssrt_pkg::StCreated;
                slot_q   <= ssrt_pkg::SlotW'(free_idx_q);
                frame_q  <= nframe_q;
                refs_q   <= ssrt_pkg::RefsW'(1);
              end else begin
                status_q <= ssrt_pkg::StFull;
                slot_q   <= '0;
                frame_q  <= '0;
                refs_q   <= '0;
              end
            end else begin
              frame_q <= '0;
              if (hit_found_q) begin
                status_q <= (hit_refs_q == '0) ? ssrt_pkg::StReleased
                                               : ssrt_pkg::StShared;
                slot_q   <= ssrt_pkg::SlotW'(hit_idx_q);
                refs_q   <= hit_refs_q;
              end else begin
                status_q <= ssrt_pkg::StNotFound;
                slot_q   <= '0;
                refs_q   <= '0;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign frame_o     = frame_q;
  assign ref_count_o = refs_q;

endmodule

@@ rtl/ssrt_ram.sv @@
// ----------------------------------------------------------------------------
// ssrt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No reset on the storage.
// ----------------------------------------------------------------------------
module ssrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ssrt_checker.sv @@
// ----------------------------------------------------------------------------
// ssrt_checker
// Port-level checks for the shared segment table, bound to the top level.
// ----------------------------------------------------------------------------
module ssrt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          opcode_i,
  input logic [ssrt_pkg::KeyW-1:0]     segment_id_i,
  input logic [ssrt_pkg::FrameW-1:0]   new_frame_i,
  input logic                          done_o,
  input logic [ssrt_pkg::StatusW-1:0]  status_o,
  input logic [ssrt_pkg::SlotW-1:0]    slot_o,
  input logic [ssrt_pkg::FrameW-1:0]   frame_o,
  input logic [ssrt_pkg::RefsW-1:0]    ref_count_o
);

  // a zero key is answered in the next cycle as invalid
  a_invalid_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && segment_id_i == '0) |=>
      (done_o && status_o == ssrt_pkg::StInvalid))
    else $error("zero key not answered as invalid in the next cycle");

  // a nonzero key starts a table pass
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && segment_id_i != '0) |=> (busy && !done_o))
    else $error("table pass did not start");

  // empty results carry zero slot, frame and count
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ssrt_pkg::StInvalid || status_o == ssrt_pkg::StFull ||
                status_o == ssrt_pkg::StNotFound)) |->
      (slot_o == '0 && frame_o == '0 && ref_count_o == '0))
    else $error("empty result with nonzero fields");

  // close results carry no frame; released means count zero, shared nonzero
  a_close_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ssrt_pkg::StShared || status_o == ssrt_pkg::StReleased)) |->
      (frame_o == '0 && ((status_o == ssrt_pkg::StReleased) == (ref_count_o == '0))))
    else $error("close result inconsistent");

  // a new entry starts at count one, a saturated one sits at the maximum
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ssrt_pkg::StCreated || status_o == ssrt_pkg::StSaturated)) |->
      (ref_count_o == ((status_o == ssrt_pkg::StCreated) ? ssrt_pkg::RefsW'(1)
                                                          : ssrt_pkg::RefsMax)))
    else $error("open count inconsistent with status");

endmodule

bind shared_segment_refcount_table_top ssrt_checker u_ssrt_checker (.*);
